### hw/rtl/pisf_pkg.sv
// ----------------------------------------------------------------------------
// pisf_pkg
// Shared types and constants of the pairwise inverse-square force unit.
// ----------------------------------------------------------------------------
package pisf_pkg;

  // Default number of position entries.
  localparam int unsigned MaxParticles = 256;

  // Widths of the arithmetic path.
  localparam int unsigned SqW   = 66;   // sum of squared differences
  localparam int unsigned RootW = 34;   // integer square root
  localparam int unsigned NumW  = 85;   // dividend |d| * C * 2^20
  localparam int unsigned DenW  = 100;  // divisor s * r
  localparam int unsigned AccW  = 96;   // per-axis force accumulator
  localparam int unsigned MulW  = 34;   // multiplier operand width

  // Configuration register indexes.
  localparam logic [3:0] RegCount = 4'd0;
  localparam logic [3:0] RegCoeff = 4'd1;

  // Request codes.
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  // Status codes.
  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatSat   = 2'd1;
  localparam logic [1:0] StatRange = 2'd2;

  // One stored particle position.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pos_t;

endpackage

### hw/rtl/pisf_pos_mem.sv
// ----------------------------------------------------------------------------
// pisf_pos_mem
// Position store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pisf_pos_mem #(
  parameter int unsigned Depth = pisf_pkg::MaxParticles
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  pisf_pkg::pos_t           wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output pisf_pkg::pos_t           rdata_o
);

  pisf_pkg::pos_t mem [Depth];
  pisf_pkg::pos_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/pisf_isqrt.sv
// ----------------------------------------------------------------------------
// pisf_isqrt
// Floor square root, one result bit per cycle (digit by digit, restoring).
// ----------------------------------------------------------------------------
module pisf_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pisf_pkg::SqW-1:0]     rad_i,
  output logic                         done_o,
  output logic [pisf_pkg::RootW-1:0]   root_o
);

  localparam int unsigned RadW = 2 * pisf_pkg::RootW;
  localparam int unsigned RemW = pisf_pkg::RootW + 2;

  logic [RadW-1:0]            rad_q;
  logic [RemW-1:0]            rem_q;
  logic [pisf_pkg::RootW-1:0] root_q;
  logic [5:0]                 cnt_q;
  logic                       run_q, done_q;
  logic [RemW+1:0]            rem_n, trial;
  logic                       ge;

  // Bring down two radicand bits and try the next root bit.
  assign rem_n = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = rem_n >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 6'(pisf_pkg::RootW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {{(RadW-pisf_pkg::SqW){1'b0}}, rad_i};
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= ge ? RemW'(rem_n - trial) : RemW'(rem_n);
      root_q <= {root_q[pisf_pkg::RootW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### hw/rtl/pisf_div.sv
// ----------------------------------------------------------------------------
// pisf_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pisf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pisf_pkg::NumW-1:0]   num_i,
  input  logic [pisf_pkg::DenW-1:0]   den_i,
  output logic                        done_o,
  output logic [pisf_pkg::NumW-1:0]   quo_o
);

  localparam int unsigned NumW = pisf_pkg::NumW;
  localparam int unsigned DenW = pisf_pkg::DenW;

  logic [NumW-1:0] num_q, quo_q;
  logic [DenW-1:0] den_q, rem_q;
  logic [6:0]      cnt_q;
  logic            run_q, done_q;
  logic [DenW:0]   rem_n;
  logic            ge;

  // Shift in the next dividend bit and compare with the divisor.
  assign rem_n = {rem_q, num_q[NumW-1]};
  assign ge    = rem_n >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 7'(NumW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[NumW-2:0], 1'b0};
      rem_q <= ge ? DenW'(rem_n - {1'b0, den_q}) : DenW'(rem_n);
      quo_q <= {quo_q[NumW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### hw/rtl/pairwise_inverse_square_force_unit.sv
// ----------------------------------------------------------------------------
// pairwise_inverse_square_force_unit
// Direct-sum inverse-square force on one particle from every other particle below the count.
// ----------------------------------------------------------------------------
// Sequencing: a load is written to the store when accepted and gives no result. An
// out-of-range query goes to StOut and strobes in the cycle after it is accepted; any
// other query reads its own entry, then for each other entry below the count forms the
// squared distance, its square root and the divisor, and divides once per nonzero axis.
// Throughput: one query at a time; busy_o stays high through the strobe cycle, and the
// receiver cannot stall. Reset: count 256, coefficient 0; the store is not cleared.
// ----------------------------------------------------------------------------
module pairwise_inverse_square_force_unit #(
  parameter int unsigned MAX_PARTICLES = pisf_pkg::MaxParticles
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               req_type_i,
  input  logic [7:0]         particle_index_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  output logic               result_valid_o,
  output logic signed [47:0] sum_fx_o,
  output logic signed [47:0] sum_fy_o,
  output logic signed [47:0] sum_fz_o,
  output logic [1:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned AW  = $clog2(MAX_PARTICLES);
  localparam int unsigned JW  = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned CW  = (JW > 9) ? JW : 9;
  localparam int unsigned AccW = pisf_pkg::AccW;
  localparam int unsigned MulW = pisf_pkg::MulW;

  // Sequencer states.
  localparam logic [4:0] StIdle = 5'd0,  StRdI  = 5'd1,  StLdI  = 5'd2,
                         StRdJ  = 5'd3,  StGetJ = 5'd4,  StSqX  = 5'd5,
                         StSqY  = 5'd6,  StSqZ  = 5'd7,  StSqE  = 5'd8,
                         StSChk = 5'd9,  StRtW  = 5'd10, StDen0 = 5'd11,
                         StDen1 = 5'd12, StDen2 = 5'd13, StAxM  = 5'd14,
                         StAxS  = 5'd15, StAxW  = 5'd16, StAxN  = 5'd17,
                         StNext = 5'd18, StOut  = 5'd19;

  logic [4:0]              state_q, state_d;
  logic [8:0]              count_q;
  logic [31:0]             coeff_q;
  logic [CW-1:0]           idx_q, j_q, cnt_eff, in_idx;
  logic [1:0]              k_q;
  logic                    oor_q;
  pisf_pkg::pos_t          pi_q, rdata;
  logic signed [32:0]      d_q [3];
  logic [32:0]             mag [3];
  logic [pisf_pkg::SqW-1:0]   s_q;
  logic [pisf_pkg::RootW-1:0] r_q, root;
  logic [pisf_pkg::DenW-1:0]  den_q;
  logic [pisf_pkg::NumW-1:0]  quo;
  logic [2*MulW-1:0]       p_q;
  logic [MulW-1:0]         mul_a, mul_b;
  logic signed [AccW-1:0]  acc_q [3];
  logic [47:0]             fsat [3];
  logic [2:0]              sat;
  logic                    accept, mem_we;
  logic [AW-1:0]           raddr;
  logic                    rt_start, rt_done, dv_start, dv_done;

  assign accept      = start_i && !busy_o;
  assign busy_o      = state_q != StIdle;
  assign cfg_ready_o = 1'b1;
  assign in_idx      = CW'(particle_index_i);
  assign cnt_eff     = (CW'(count_q) < CW'(MAX_PARTICLES)) ? CW'(count_q)
                                                           : CW'(MAX_PARTICLES);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 9'd256;
      coeff_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pisf_pkg::RegCount: count_q <= cfg_data_i[8:0];
        pisf_pkg::RegCoeff: coeff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Position store.
  assign mem_we = accept && req_type_i == pisf_pkg::ReqLoad
                  && in_idx < CW'(MAX_PARTICLES);
  assign raddr  = (state_q == StRdI) ? idx_q[AW-1:0] : j_q[AW-1:0];

  pisf_pos_mem #(.Depth(MAX_PARTICLES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (in_idx[AW-1:0]),
    .wdata_i ({pos_x_i, pos_y_i, pos_z_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Shared square root and divider.
  assign rt_start = state_q == StSChk && s_q != '0;
  assign dv_start = state_q == StAxS;

  pisf_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rt_start),
    .rad_i   (s_q),
    .done_o  (rt_done),
    .root_o  (root)
  );

  pisf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   ({p_q[64:0], 20'd0}),
    .den_i   (den_q),
    .done_o  (dv_done),
    .quo_o   (quo)
  );

  // Magnitudes of the coordinate differences.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = d_q[k][32] ? 33'(-d_q[k]) : 33'(d_q[k]);
    end
  end

  // Operand selection of the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StSqX:  begin mul_a = MulW'(mag[0]); mul_b = MulW'(mag[0]); end
      StSqY:  begin mul_a = MulW'(mag[1]); mul_b = MulW'(mag[1]); end
      StSqZ:  begin mul_a = MulW'(mag[2]); mul_b = MulW'(mag[2]); end
      StDen0: begin mul_a = MulW'(s_q[32:0]); mul_b = r_q; end
      StDen1: begin mul_a = MulW'(s_q[65:33]); mul_b = r_q; end
      StAxM:  begin mul_a = MulW'(mag[k_q]); mul_b = MulW'(coeff_q); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && req_type_i == pisf_pkg::ReqQuery) begin
          state_d = (in_idx >= cnt_eff) ? StOut : StRdI;
        end
      end
      StRdI:  state_d = StLdI;
      StLdI:  state_d = StRdJ;
      StRdJ:  state_d = (j_q == idx_q) ? StNext : StGetJ;
      StGetJ: state_d = StSqX;
      StSqX:  state_d = StSqY;
      StSqY:  state_d = StSqZ;
      StSqZ:  state_d = StSqE;
      StSqE:  state_d = StSChk;
      StSChk: state_d = (s_q == '0) ? StNext : StRtW;
      StRtW:  if (rt_done) state_d = StDen0;
      StDen0: state_d = StDen1;
      StDen1: state_d = StDen2;
      StDen2: state_d = StAxM;
      StAxM:  state_d = (d_q[k_q] == '0) ? StAxN : StAxS;
      StAxS:  state_d = StAxW;
      StAxW:  if (dv_done) state_d = StAxN;
      StAxN:  state_d = (k_q == 2'd2) ? StNext : StAxM;
      StNext: state_d = (j_q + CW'(1) == cnt_eff) ? StOut : StRdJ;
      StOut:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers of the walk.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        idx_q <= in_idx;
        oor_q <= in_idx >= cnt_eff;
        j_q   <= '0;
        for (int k = 0; k < 3; k++) acc_q[k] <= '0;
      end
      StLdI:  pi_q <= rdata;
      StGetJ: begin
        d_q[0] <= 33'(pi_q.x) - 33'(rdata.x);
        d_q[1] <= 33'(pi_q.y) - 33'(rdata.y);
        d_q[2] <= 33'(pi_q.z) - 33'(rdata.z);
        s_q    <= '0;
      end
      StSqY, StSqZ, StSqE: s_q <= s_q + pisf_pkg::SqW'(p_q);
      StRtW:  begin
        r_q <= root;
        k_q <= '0;
      end
      StDen1: den_q <= pisf_pkg::DenW'(p_q);
      StDen2: den_q <= den_q + {p_q[66:0], 33'd0};
      StAxW:  begin
        if (dv_done) begin
          acc_q[k_q] <= d_q[k_q][32] ? acc_q[k_q] - AccW'(quo)
                                     : acc_q[k_q] + AccW'(quo);
        end
      end
      StAxN:  k_q <= k_q + 2'd1;
      StNext: j_q <= j_q + CW'(1);
      default: ;
    endcase
  end

  // Saturation of the finished sums to 48 bits.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sat[k]  = !((&acc_q[k][AccW-1:47]) || (~|acc_q[k][AccW-1:47]));
      fsat[k] = sat[k] ? (acc_q[k][AccW-1] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF)
                       : acc_q[k][47:0];
    end
  end

  assign result_valid_o = state_q == StOut;
  assign sum_fx_o       = fsat[0];
  assign sum_fy_o       = fsat[1];
  assign sum_fz_o       = fsat[2];
  assign status_o       = oor_q    ? pisf_pkg::StatRange :
                          (|sat)   ? pisf_pkg::StatSat   : pisf_pkg::StatOk;

endmodule

### hw/rtl/pisf_checker.sv
// ----------------------------------------------------------------------------
// pisf_checker
// Port-level checks of the force unit, bound to the top level.
// ----------------------------------------------------------------------------
module pisf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               req_type_i,
  input logic               result_valid_o,
  input logic signed [47:0] sum_fx_o,
  input logic signed [47:0] sum_fy_o,
  input logic signed [47:0] sum_fz_o,
  input logic [1:0]         status_o
);

  // A result only appears while a query is in progress, and ends it.
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o ##1 !busy_o) else $error("result outside query");

  // A load never occupies the unit.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_type_i == pisf_pkg::ReqLoad |=> !busy_o)
    else $error("load made unit busy");

  // An out-of-range answer carries zero forces.
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == pisf_pkg::StatRange |->
      sum_fx_o == '0 && sum_fy_o == '0 && sum_fz_o == '0)
    else $error("nonzero force with range status");

  // Status takes only defined codes.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> status_o != 2'd3) else $error("bad status");

endmodule

bind pairwise_inverse_square_force_unit pisf_checker u_pisf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .req_type_i     (req_type_i),
  .result_valid_o (result_valid_o),
  .sum_fx_o       (sum_fx_o),
  .sum_fy_o       (sum_fy_o),
  .sum_fz_o       (sum_fz_o),
  .status_o       (status_o)
);

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pairwise inverse-square force unit. Loads and
// queries are driven at the falling edge in random bursts. A predictor works
// out each expected force sum, and a checker compares every result strobe
// with the oldest expected sum.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumEntries = 256;
  localparam longint unsigned CycleLimit = 4000000;

  // Expected contents of one result item.
  typedef struct {
    logic signed [47:0] fx;
    logic signed [47:0] fy;
    logic signed [47:0] fz;
    logic [1:0]         status;
  } force_sum_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               req_type_i;
  logic [7:0]         particle_index_i;
  logic signed [31:0] pos_x_i;
  logic signed [31:0] pos_y_i;
  logic signed [31:0] pos_z_i;
  logic               result_valid_o;
  logic signed [47:0] sum_fx_o;
  logic signed [47:0] sum_fy_o;
  logic signed [47:0] sum_fz_o;
  logic [1:0]         status_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [3:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  // Shadow copy of the block's registers and position store.
  logic [8:0]         shadow_count;
  logic [31:0]        shadow_coeff;
  logic signed [31:0] shadow_x [NumEntries];
  logic signed [31:0] shadow_y [NumEntries];
  logic signed [31:0] shadow_z [NumEntries];
  bit                 loaded [NumEntries];

  force_sum_t         pending_sums[$];
  int                 fail_count;
  longint unsigned    cycle_count = 0;
  int                 burst_left;

  pairwise_inverse_square_force_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .req_type_i       (req_type_i),
    .particle_index_i (particle_index_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .result_valid_o   (result_valid_o),
    .sum_fx_o         (sum_fx_o),
    .sum_fy_o         (sum_fy_o),
    .sum_fz_o         (sum_fz_o),
    .status_o         (status_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Cycle counter that ends a run that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[pairwise_inverse_square_force_unit] ERROR");
      $finish;
    end
  end

  // Floor square root of a sum of squares below 2^66.
  function automatic logic [127:0] floor_root(input logic [127:0] s);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  // Clamp a wide sum to 48 bits, flagging the clamp.
  function automatic logic signed [47:0] clamp48(input logic signed [127:0] a,
                                                 inout bit clamped);
    if (a > 128'sd140737488355327) begin
      clamped = 1'b1;
      return 48'sh7FFF_FFFF_FFFF;
    end
    if (a < -128'sd140737488355328) begin
      clamped = 1'b1;
      return 48'sh8000_0000_0000;
    end
    return a[47:0];
  endfunction

  // Force on particle idx from every other particle below the active count.
  function automatic force_sum_t force_on(input int idx);
    force_sum_t         res;
    int                 active;
    longint             d [3];
    logic [127:0]       mag [3];
    logic [127:0]       s;
    logic [127:0]       den;
    logic [127:0]       quo;
    logic signed [127:0] acc [3];
    bit                 clamped;
    active = (shadow_count > NumEntries) ? NumEntries : int'(shadow_count);
    res = '{fx: '0, fy: '0, fz: '0, status: pisf_pkg::StatRange};
    if (idx >= active) return res;
    acc = '{default: '0};
    clamped = 1'b0;
    for (int j = 0; j < active; j++) begin
      if (j == idx) continue;
      d[0] = longint'(shadow_x[idx]) - longint'(shadow_x[j]);
      d[1] = longint'(shadow_y[idx]) - longint'(shadow_y[j]);
      d[2] = longint'(shadow_z[idx]) - longint'(shadow_z[j]);
      s = '0;
      for (int k = 0; k < 3; k++) begin
        mag[k] = (d[k] < 0) ? 128'(-d[k]) : 128'(d[k]);
        s += mag[k] * mag[k];
      end
      // Coincident particles contribute nothing.
      if (s == 0) continue;
      den = s * floor_root(s);
      for (int k = 0; k < 3; k++) begin
        if (d[k] == 0) continue;
        quo = ((mag[k] * 128'(shadow_coeff)) << 20) / den;
        if (d[k] < 0) acc[k] -= $signed(quo);
        else acc[k] += $signed(quo);
      end
    end
    res.fx = clamp48(acc[0], clamped);
    res.fy = clamp48(acc[1], clamped);
    res.fz = clamp48(acc[2], clamped);
    res.status = clamped ? pisf_pkg::StatSat : pisf_pkg::StatOk;
    return res;
  endfunction

  // Result checker: each strobe is matched against the oldest expected sum.
  always @(posedge clk_i) begin
    force_sum_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result: fx=%0d fy=%0d fz=%0d status=%0d",
               sum_fx_o, sum_fy_o, sum_fz_o, status_o);
        fail_count++;
      end else begin
        want = pending_sums.pop_front();
        if (sum_fx_o !== want.fx) begin
          $error("sum_fx: expected %0d, got %0d", want.fx, sum_fx_o);
          fail_count++;
        end
        if (sum_fy_o !== want.fy) begin
          $error("sum_fy: expected %0d, got %0d", want.fy, sum_fy_o);
          fail_count++;
        end
        if (sum_fz_o !== want.fz) begin
          $error("sum_fz: expected %0d, got %0d", want.fz, sum_fz_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
      end
    end
  end

  // Send one item, with random gaps between bursts.
  task automatic send_item(input logic kind, input logic [7:0] idx,
                           input logic signed [31:0] px,
                           input logic signed [31:0] py,
                           input logic signed [31:0] pz);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    start_i          <= 1'b1;
    req_type_i       <= kind;
    particle_index_i <= idx;
    pos_x_i          <= px;
    pos_y_i          <= py;
    pos_z_i          <= pz;
    // The item is taken at the next rising edge, so update the shadow now.
    if (kind == pisf_pkg::ReqLoad) begin
      shadow_x[idx] = px;
      shadow_y[idx] = py;
      shadow_z[idx] = pz;
      loaded[idx] = 1'b1;
    end else begin
      pending_sums.push_back(force_on(int'(idx)));
    end
    @(posedge clk_i);
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  task automatic load_particle(input int idx, input logic signed [31:0] px,
                               input logic signed [31:0] py,
                               input logic signed [31:0] pz);
    send_item(pisf_pkg::ReqLoad, 8'(idx), px, py, pz);
  endtask

  task automatic query_particle(input int idx);
    send_item(pisf_pkg::ReqQuery, 8'(idx), $urandom, $urandom, $urandom);
  endtask

  // Write a register once every outstanding query has answered.
  task automatic write_reg(input logic [3:0] index, input logic [31:0] value);
    while (pending_sums.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    #1;
    while (!cfg_ready_o) begin
      @(negedge clk_i);
      #1;
    end
    if (index == pisf_pkg::RegCount) shadow_count = value[8:0];
    else if (index == pisf_pkg::RegCoeff) shadow_coeff = value;
    @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Special cases: coincident particles, range and unknown registers.
  task automatic test_special_cases();
    write_reg(pisf_pkg::RegCount, 9'd3);
    // Particles 0 and 1 sit one raw step apart; particle 2 coincides with 1.
    load_particle(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000);
    load_particle(1, 32'sh7FFF_FFFE, 32'sh8000_0000, 32'sh0000_0000);
    load_particle(2, 32'sh7FFF_FFFE, 32'sh8000_0000, 32'sh0000_0000);
    query_particle(0);
    query_particle(1);
    query_particle(2);
    query_particle(3);
    query_particle(200);
    // Extreme separation with the smallest nonzero coefficient.
    write_reg(pisf_pkg::RegCoeff, 32'd1);
    load_particle(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    load_particle(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    query_particle(0);
    query_particle(1);
    write_reg(pisf_pkg::RegCoeff, 32'd0);
    query_particle(2);
    // A count of zero answers every query out of range.
    write_reg(pisf_pkg::RegCount, 9'd0);
    query_particle(0);
    // Unknown register indexes must leave the settings alone.
    write_reg(4'd7, 32'd5);
    write_reg(4'hF, 32'hFFFF_FFFF);
    write_reg(pisf_pkg::RegCoeff, 32'h8000_0000);
    write_reg(pisf_pkg::RegCount, 9'd1);
    query_particle(0);
    query_particle(1);
  endtask

  // Random phases of loads and queries over small particle sets.
  task automatic test_random_traffic();
    int items;
    int active;
    int pick;
    int idx;
    bit clustered;
    logic signed [31:0] base [3];
    logic signed [31:0] p [3];
    items = 0;
    while (items < 80) begin
      pick = $urandom_range(0, 9);
      active = (pick < 7) ? $urandom_range(2, 8) : (pick == 7) ? 1 : $urandom_range(9, 16);
      write_reg(pisf_pkg::RegCount, 32'(active));
      case ($urandom_range(0, 3))
        0:       write_reg(pisf_pkg::RegCoeff, 32'hFFFF_FFFF);
        1:       write_reg(pisf_pkg::RegCoeff, $urandom_range(0, 65535));
        default: write_reg(pisf_pkg::RegCoeff, $urandom);
      endcase
      clustered = $urandom_range(0, 1);
      for (int k = 0; k < 3; k++) base[k] = $urandom;
      for (int n = 0; n < 8; n++) begin
        // Keep every entry below the count loaded before a query reads it.
        idx = -1;
        for (int i = 0; i < active; i++)
          if (!loaded[i] && idx < 0) idx = i;
        if (idx < 0 && $urandom_range(0, 9) < 4)
          idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(0, active - 1);
        if (idx >= 0) begin
          for (int k = 0; k < 3; k++)
            p[k] = clustered ? base[k] + $signed($urandom_range(0, 1023)) - 512
                             : $signed($urandom);
          load_particle(idx, p[0], p[1], p[2]);
        end else begin
          query_particle(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, active - 1));
        end
        items++;
      end
    end
  endtask

  initial begin
    start_i          = 1'b0;
    req_type_i       = pisf_pkg::ReqLoad;
    particle_index_i = '0;
    pos_x_i          = '0;
    pos_y_i          = '0;
    pos_z_i          = '0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = pisf_pkg::RegCount;
    cfg_data_i       = '0;
    shadow_count     = 9'd256;
    shadow_coeff     = '0;
    fail_count       = 0;
    burst_left       = 0;
    for (int i = 0; i < NumEntries; i++) loaded[i] = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_special_cases();
    test_random_traffic();

    // Drain the outstanding queries, then let the bench idle before the verdict.
    while (pending_sums.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[pairwise_inverse_square_force_unit] OK");
    end else begin
      $display("[pairwise_inverse_square_force_unit] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/pisf_pkg.sv
hw/rtl/pisf_pos_mem.sv
hw/rtl/pisf_isqrt.sv
hw/rtl/pisf_div.sv
hw/rtl/pairwise_inverse_square_force_unit.sv
hw/rtl/pisf_checker.sv
sim/testbench.sv
